// ===== rtl/xsort_pkg.sv =====
// Shared constants, command/status structs and types for the exchange sorter.
package xsort_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // read address source for the element store
    typedef enum logic [1:0] {
        RD_I  = 2'd0,
        RD_I1 = 2'd1,
        RD_J1 = 2'd2,
        RD_K  = 2'd3
    } t_rd_src;

    typedef struct packed {
        logic    store;      // write the item if there is room, else set drop
        logic    clear_set;  // set is done: empty count and drop flag
        logic    rd_en;
        t_rd_src rd_src;
        logic    fetch;      // hold store[i] as pivot, j = i + 1
        logic    scan;       // compare pivot with store[j], swap, advance j
        logic    wback;      // write pivot back to store[i], advance i
        logic    out_load;   // load store[k] into the output register, advance k
    } t_cmd;

    typedef struct packed {
        logic             count_nz;
        logic             j_last;
        logic             i_last;
        logic             k_last;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } t_stat;

endpackage

// ===== rtl/xsort_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module xsort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/xsort_dp.sv =====
// Datapath: element store, set count, sort indices, pivot and output register.
module xsort_dp
    import xsort_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [DATA_W-1:0] i_value,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [DATA_W-1:0] o_out_value,
    output logic              o_out_last,
    output logic              o_out_ovf
);

    logic [CNT_W-1:0]  r_count;
    logic              r_drop;
    logic [IDX_W-1:0]  r_i;
    logic [IDX_W-1:0]  r_j;
    logic [IDX_W-1:0]  r_k;
    logic [DATA_W-1:0] r_held;
    logic              r_ovalid;
    logic [DATA_W-1:0] r_odata;
    logic              r_olast;
    logic              r_oovf;

    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
    logic [DATA_W-1:0] rdata;
    logic              room;
    logic              swap;

    assign room = r_count < CNT_W'(CAPACITY);
    assign swap = $signed(r_held) > $signed(rdata);

    always_comb begin
        we    = 1'b0;
        waddr = r_count[IDX_W-1:0];
        wdata = i_value;
        if (i_cmd.store) begin
            we = room;
        end else if (i_cmd.scan) begin
            we    = swap;
            waddr = r_j;
            wdata = r_held;
        end else if (i_cmd.wback) begin
            we    = 1'b1;
            waddr = r_i;
            wdata = r_held;
        end
    end

    always_comb begin
        case (i_cmd.rd_src)
            RD_I:    raddr = r_i;
            RD_I1:   raddr = r_i + IDX_W'(1);
            RD_J1:   raddr = r_j + IDX_W'(1);
            RD_K:    raddr = r_k;
            default: raddr = r_k;
        endcase
    end

    xsort_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.store) begin
                r_i <= '0;
                r_k <= '0;
                if (room) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.clear_set) begin
                r_count <= '0;
                r_drop  <= 1'b0;
            end
            if (i_cmd.fetch) begin
                r_j <= r_i + IDX_W'(1);
            end
            if (i_cmd.scan) begin
                r_j <= r_j + IDX_W'(1);
            end
            if (i_cmd.wback) begin
                r_i <= r_i + IDX_W'(1);
            end
            if (i_cmd.out_load) begin
                r_k      <= r_k + IDX_W'(1);
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // pivot follows the smaller value on every swap
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch || (i_cmd.scan && swap)) begin
            r_held <= rdata;
        end
        if (i_cmd.out_load) begin
            r_odata <= rdata;
            r_olast <= o_stat.k_last;
            r_oovf  <= r_drop;
        end
    end

    assign o_stat.count_nz = r_count != '0;
    assign o_stat.j_last   = CNT_W'(r_j) + CNT_W'(1) == r_count;
    assign o_stat.i_last   = CNT_W'(r_i) + CNT_W'(2) == r_count;
    assign o_stat.k_last   = CNT_W'(r_k) + CNT_W'(1) == r_count;
    assign o_stat.out_free = !r_ovalid || i_out_ready;
    assign o_stat.count    = r_count;

    assign o_out_valid = r_ovalid;
    assign o_out_value = r_odata;
    assign o_out_last  = r_olast;
    assign o_out_ovf   = r_oovf;

endmodule

// ===== rtl/xsort_ctrl.sv =====
// Controller: load, compare-swap passes and emit sequencing.
module xsort_ctrl
    import xsort_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_last,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_LOAD    = 7'b0000001,
        S_PREP    = 7'b0000010,
        S_FETCH   = 7'b0000100,
        S_SCAN    = 7'b0001000,
        S_WBACK   = 7'b0010000,
        S_EMIT_RD = 7'b0100000,
        S_EMIT_LD = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = r_state == S_LOAD;
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_src = RD_K;
        case (r_state)
            S_LOAD: begin
                o_cmd.store = accept;
                if (accept && i_in_last) begin
                    // a single element needs no pass
                    n_state = i_stat.count_nz ? S_PREP : S_EMIT_RD;
                end
            end
            S_PREP: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = RD_I;
                n_state      = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.fetch  = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = RD_I1;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan   = 1'b1;
                o_cmd.rd_en  = !i_stat.j_last;
                o_cmd.rd_src = RD_J1;
                if (i_stat.j_last) begin
                    n_state = S_WBACK;
                end
            end
            S_WBACK: begin
                o_cmd.wback  = 1'b1;
                o_cmd.rd_en  = !i_stat.i_last;
                o_cmd.rd_src = RD_I1;
                n_state      = i_stat.i_last ? S_EMIT_RD : S_FETCH;
            end
            S_EMIT_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = RD_K;
                n_state      = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                // hold read data until the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_stat.k_last) begin
                        o_cmd.clear_set = 1'b1;
                        n_state         = S_LOAD;
                    end else begin
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/ascending_exchange_sort.sv =====
// Top level of the exchange sorter: ports, controller, datapath and checks.
//
//  channel  dir  tdata                    tlast    tuser
//  s_axis   in   [31:0] sample_value      set_end  -
//  m_axis   out  [31:0] sorted_value      run_end  [0] overflowed
//
//  Load: one item per cycle. After the last item of a set the sort runs a pass
//  for each stored element but the last (fetch pivot, scan, write back), bound by
//  the single read and write port of the element store.
//  Emit: per result a store read, then an output register load that waits while
//  m_axis_tready is low. Items are accepted only between sets; the last result
//  may still wait in the output register when the next set starts loading.
//  Reset (i_rst_n low, synchronous) empties the set and the output register.
module ascending_exchange_sort
    import xsort_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sample_value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] overflowed
);

    t_cmd  cmd;
    t_stat stat;

    xsort_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    xsort_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_value     (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_value (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_ovf   (m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.count <= CNT_W'(CAPACITY))
        else $error("set count beyond capacity");

    a_stop_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input still ready after the last item of a set");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.out_load))
        else $error("output valid without a result load");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_load && stat.k_last) |=> (stat.count == '0 && s_axis_tready))
        else $error("set not cleared after its last result");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the ascending exchange sorter: directed and random sets.
module testbench;
    import xsort_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int IDLE_PCT      = 23;
    localparam int RANDOM_TARGET = 250;
    localparam int ITEM_TARGET   = 360;
    localparam int HOLD_LEN      = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 200;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     run_end;
        logic                     overflowed;
    } t_sorted_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // [31:0] sample_value
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] sorted_value
    logic        m_axis_tlast;
    logic        m_axis_tuser;         // [0] overflowed

    always #HALF_PERIOD i_clk = ~i_clk;

    ascending_exchange_sort u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    logic signed [DATA_W-1:0] open_set [$];
    logic                     set_dropped = 1'b0;
    t_sorted_item             sorted_expect [$];

    int errors       = 0;
    int items_sent   = 0;
    bit src_gaps     = 1'b1;
    bit rx_gaps      = 1'b1;
    int hold_req_cnt = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    // Collect one accepted item; on the set end, sort and queue the results.
    function automatic void collect_and_sort(input logic signed [DATA_W-1:0] value,
                                             input logic last);
        logic signed [DATA_W-1:0] work [CAPACITY];
        logic signed [DATA_W-1:0] swap_tmp;
        int n;
        t_sorted_item res;
        if (open_set.size() < CAPACITY)
            open_set.push_back(value);
        else
            set_dropped = 1'b1;
        if (!last)
            return;
        n = open_set.size();
        for (int k = 0; k < n; k++)
            work[k] = open_set[k];
        for (int i = 0; i + 1 < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
                if (work[i] > work[j]) begin
                    swap_tmp = work[i];
                    work[i]  = work[j];
                    work[j]  = swap_tmp;
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            res.value      = work[k];
            res.run_end    = (k + 1 == n);
            res.overflowed = set_dropped;
            sorted_expect.push_back(res);
        end
        open_set.delete();
        set_dropped = 1'b0;
    endfunction

    function automatic logic [31:0] pick_sample(input int mode);
        logic [31:0] v;
        case (mode)
            0: v = $urandom;
            1: v = $urandom_range(7) - 3;   // narrow range: many duplicates
            default: begin
                case ($urandom_range(5))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'h8000_0001;
                    3: v = 32'h7fff_fffe;
                    4: v = 32'hffff_ffff;
                    default: v = '0;
                endcase
            end
        endcase
        return v;
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_item(input logic [31:0] value, input logic last);
        if (src_gaps) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        collect_and_sort(value, last);
        items_sent++;
    endtask

    task automatic send_set(input logic [31:0] vals [$]);
        for (int k = 0; k < vals.size(); k++)
            send_item(vals[k], k == vals.size() - 1);
    endtask

    task automatic send_random_set(input int size);
        logic [31:0] vals [$];
        int mode;
        mode = $urandom_range(3);
        for (int k = 0; k < size; k++)
            vals.push_back(pick_sample(mode == 3 ? $urandom_range(2) : mode));
        send_set(vals);
    endtask

    task automatic run_random_sets(input int target);
        int r;
        int size;
        while (items_sent < target) begin
            r = $urandom_range(99);
            if (r < 70)
                size = $urandom_range(8, 1);
            else if (r < 88)
                size = $urandom_range(CAPACITY, 9);
            else
                size = $urandom_range(CAPACITY + 8, CAPACITY + 1);
            send_random_set(size);
        end
    endtask

    task automatic test_single_element();
        send_set('{32'h7fff_ffff});
    endtask

    task automatic test_extremes();
        send_set('{32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h8000_0000});
    endtask

    task automatic test_equal_values();
        send_set('{32'd5, -32'sd5, 32'd5});
    endtask

    // Seventeen items in descending order: the final one is dropped, the set still ends.
    task automatic test_store_full();
        logic [31:0] vals [$];
        for (int k = CAPACITY; k >= 0; k--)
            vals.push_back(k);
        send_set(vals);
    endtask

    // Stall the receiver long enough for the block to back up into its input.
    task automatic test_backpressure();
        src_gaps = 1'b0;
        hold_req_cnt++;
        repeat (3)
            send_random_set(CAPACITY);
        src_gaps = 1'b1;
    endtask

    task automatic test_random_sets(input int target);
        src_gaps = 1'b1;
        rx_gaps  = 1'b1;
        run_random_sets(target);
    endtask

    task automatic test_no_idle(input int target);
        src_gaps = 1'b0;
        rx_gaps  = 1'b0;
        run_random_sets(target);
    endtask

    always @(posedge i_clk) begin
        if (hold_req_cnt != hold_seen) begin
            hold_seen = hold_req_cnt;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_gaps) begin
            m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_sorted_item exp_item;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (sorted_expect.size() == 0) begin
                $error("unexpected result: sorted_value %0d", $signed(m_axis_tdata));
                errors++;
            end else begin
                exp_item = sorted_expect.pop_front();
                if (m_axis_tdata !== exp_item.value) begin
                    $error("sorted_value: expected %0d, got %0d",
                           exp_item.value, $signed(m_axis_tdata));
                    errors++;
                end
                if (m_axis_tlast !== exp_item.run_end) begin
                    $error("run_end: expected %0b, got %0b", exp_item.run_end, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tuser !== exp_item.overflowed) begin
                    $error("overflowed: expected %0b, got %0b",
                           exp_item.overflowed, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("ascending_exchange_sort regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_element();
        test_extremes();
        test_equal_values();
        test_store_full();
        test_backpressure();
        test_random_sets(RANDOM_TARGET);
        test_no_idle(ITEM_TARGET);
        s_axis_tvalid <= 1'b0;
        while (sorted_expect.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("ascending_exchange_sort regression: pass");
        else
            $display("ascending_exchange_sort regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/xsort_pkg.sv
rtl/xsort_ram.sv
rtl/xsort_dp.sv
rtl/xsort_ctrl.sv
rtl/ascending_exchange_sort.sv
tb/testbench.sv
